// File: design/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg : shared types and constants for the linked list segment swap core
// Request kinds, sequencer states, swap relink modes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lls_pkg;

   // fixed width of every element field on the ports
   localparam int ELEM_W = 11;
   localparam int KIND_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_SWAP   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND2,
      ST_SW_RD2,
      ST_SW_CAP,
      ST_SW_JOIN,
      ST_TAIL_RD,
      ST_TAIL_CAP,
      ST_RD_CHK,
      ST_RD_OUT
   } state_type;

   // how the two segments sit relative to each other
   typedef enum logic [1:0] {
      MODE_FIRST_BEFORE,
      MODE_SECOND_BEFORE,
      MODE_APART
   } mode_type;

   // join steps per swap are at most four
   localparam int STEP_W = 2;

endpackage

`default_nettype wire

// File: design/linked_list_segment_swap_core.sv
// ----------------------------------------------------------------------------
// linked_list_segment_swap_core : doubly linked list with segment swap
// Next/prev link tables indexed by value, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Keeps an ordered list of distinct values 1..MAX_ELEMENTS as two link RAMs
// (next and prev), with slot 0 as head and slot MAX_ELEMENTS+1 as tail.
// A request is taken when start is high and busy is low; busy stays high
// while the sequencer works. A swap reads the four neighbor links in two
// rounds (each link RAM has one read port), makes one relink per join
// step (one write per RAM at a time), then reads the tail's prev link to
// find the new append point. Clears never raise busy; rejected appends and
// swaps (a value of 0 or above MAX_ELEMENTS) never raise busy and change
// nothing; a read at the end of the list gives no result.
// A read that finds an element returns it on rsp_element/rsp_is_last with
// rsp_valid high for exactly one cycle, the first cycle with busy low. The
// receiver cannot stall, so the result must be captured on that edge.
// Link RAMs are not cleared after reset; issue a clear request first.
// Segments given to a swap are trusted to be disjoint and in the list.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_segment_swap_core #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [lls_pkg::KIND_W-1:0] req_kind,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_item_value,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_first_start,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_first_end,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_second_start,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_second_end,
   output logic                            rsp_valid,
   output logic      [lls_pkg::ELEM_W-1:0] rsp_element,
   output logic                            rsp_is_last
);

   localparam int SLOT_COUNT = MAX_ELEMENTS + 2;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int WIDE_W     = (SLOT_W > lls_pkg::ELEM_W) ? SLOT_W : lls_pkg::ELEM_W;

   localparam logic [SLOT_W-1:0] HEAD_SLOT = '0;
   localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(MAX_ELEMENTS + 1);
   localparam logic [31:0]       MAX_U     = 32'(MAX_ELEMENTS);

   // ---- port fields to slot width -----------------------------------------
   logic [WIDE_W-1:0] item_wide, fs_wide, fe_wide, ss_wide, se_wide;
   logic [SLOT_W-1:0] item_slot, fs_slot, fe_slot, ss_slot, se_slot;
   logic              item_ok, fs_ok, fe_ok, ss_ok, se_ok;

   assign item_wide = WIDE_W'(req_item_value);
   assign fs_wide   = WIDE_W'(req_first_start);
   assign fe_wide   = WIDE_W'(req_first_end);
   assign ss_wide   = WIDE_W'(req_second_start);
   assign se_wide   = WIDE_W'(req_second_end);

   assign item_slot = item_wide[SLOT_W-1:0];
   assign fs_slot   = fs_wide[SLOT_W-1:0];
   assign fe_slot   = fe_wide[SLOT_W-1:0];
   assign ss_slot   = ss_wide[SLOT_W-1:0];
   assign se_slot   = se_wide[SLOT_W-1:0];

   // value must be 1..MAX_ELEMENTS, otherwise the request is a no-op
   assign item_ok = (req_item_value   != '0) && (32'(req_item_value)   <= MAX_U);
   assign fs_ok   = (req_first_start  != '0) && (32'(req_first_start)  <= MAX_U);
   assign fe_ok   = (req_first_end    != '0) && (32'(req_first_end)    <= MAX_U);
   assign ss_ok   = (req_second_start != '0) && (32'(req_second_start) <= MAX_U);
   assign se_ok   = (req_second_end   != '0) && (32'(req_second_end)   <= MAX_U);

   // ---- link RAM ports -----------------------------------------------------
   logic              nxt_we, prv_we;
   logic [SLOT_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic [SLOT_W-1:0] nxt_ra, prv_ra;
   logic [SLOT_W-1:0] nxt_q, prv_q;

   lls_link_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (SLOT_W)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (nxt_ra),
      .rd_data (nxt_q)
   );

   lls_link_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (SLOT_W)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (prv_ra),
      .rd_data (prv_q)
   );

   // ---- state --------------------------------------------------------------
   lls_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]  ap_ff, ap_in;             // append point
   logic [SLOT_W-1:0]  rc_ff, rc_in;             // read cursor
   logic               rsp_valid_ff, rsp_valid_in;

   // payload: segment ends (a1 doubles as the appended value)
   logic [SLOT_W-1:0]  a1_ff, a1_in, b1_ff, b1_in, a2_ff, a2_in, b2_ff, b2_in;
   logic [SLOT_W-1:0]  before1_ff, before1_in, after1_ff, after1_in;
   logic [SLOT_W-1:0]  before2_ff, before2_in, after2_ff, after2_in;
   lls_pkg::mode_type  mode_ff, mode_in;
   logic [lls_pkg::STEP_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;           // element being read
   logic [WIDE_W-1:0]  cur_wide;
   logic [lls_pkg::ELEM_W-1:0] rsp_element_ff, rsp_element_in;
   logic               rsp_is_last_ff, rsp_is_last_in;

   // ---- relink step selection ---------------------------------------------
   // join(a,b): next[a] = b, prev[b] = a; applied in order, one per cycle,
   // so aliasing between the pairs resolves as a sequential rewrite would
   logic [SLOT_W-1:0] join_a, join_b;
   logic              join_last;

   always_comb begin
      join_a    = before1_ff;
      join_b    = a2_ff;
      join_last = 1'b0;
      unique case (mode_ff)
         lls_pkg::MODE_FIRST_BEFORE: begin
            unique case (step_ff)
               2'd0: begin join_a = before1_ff; join_b = a2_ff; end
               2'd1: begin join_a = b2_ff; join_b = a1_ff; end
               default: begin
                  join_a = b1_ff; join_b = after2_ff; join_last = 1'b1;
               end
            endcase
         end
         lls_pkg::MODE_SECOND_BEFORE: begin
            unique case (step_ff)
               2'd0: begin join_a = before2_ff; join_b = a1_ff; end
               2'd1: begin join_a = b1_ff; join_b = a2_ff; end
               default: begin
                  join_a = b2_ff; join_b = after1_ff; join_last = 1'b1;
               end
            endcase
         end
         default: begin
            unique case (step_ff)
               2'd0: begin join_a = before1_ff; join_b = a2_ff; end
               2'd1: begin join_a = b2_ff; join_b = after1_ff; end
               2'd2: begin join_a = before2_ff; join_b = a1_ff; end
               default: begin
                  join_a = b1_ff; join_b = after2_ff; join_last = 1'b1;
               end
            endcase
         end
      endcase
   end

   assign cur_wide = WIDE_W'(cur_ff);

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      ap_in          = ap_ff;
      rc_in          = rc_ff;
      rsp_valid_in   = 1'b0;
      a1_in          = a1_ff;
      b1_in          = b1_ff;
      a2_in          = a2_ff;
      b2_in          = b2_ff;
      before1_in     = before1_ff;
      after1_in      = after1_ff;
      before2_in     = before2_ff;
      after2_in      = after2_ff;
      mode_in        = mode_ff;
      step_in        = step_ff;
      cur_in         = cur_ff;
      rsp_element_in = rsp_element_ff;
      rsp_is_last_in = rsp_is_last_ff;

      nxt_we = 1'b0;
      nxt_wa = join_a;
      nxt_wd = join_b;
      prv_we = 1'b0;
      prv_wa = join_b;
      prv_wd = join_a;
      nxt_ra = rc_ff;
      prv_ra = fs_slot;

      unique case (state_ff)
         lls_pkg::ST_IDLE: begin
            // launch the first reads from the request fields (swap) or the read cursor
            nxt_ra = (req_kind == lls_pkg::KIND_SWAP) ? fe_slot : rc_ff;
            prv_ra = fs_slot;
            if (start) begin
               unique case (req_kind)
                  lls_pkg::KIND_CLEAR: begin
                     nxt_we = 1'b1; nxt_wa = HEAD_SLOT; nxt_wd = TAIL_SLOT;
                     prv_we = 1'b1; prv_wa = TAIL_SLOT; prv_wd = HEAD_SLOT;
                     ap_in  = HEAD_SLOT;
                     rc_in  = HEAD_SLOT;
                  end
                  lls_pkg::KIND_APPEND: begin
                     if (item_ok) begin
                        nxt_we   = 1'b1; nxt_wa = ap_ff;     nxt_wd = item_slot;
                        prv_we   = 1'b1; prv_wa = item_slot; prv_wd = ap_ff;
                        a1_in    = item_slot;
                        state_in = lls_pkg::ST_APPEND2;
                     end
                  end
                  lls_pkg::KIND_SWAP: begin
                     if (fs_ok && fe_ok && ss_ok && se_ok) begin
                        a1_in    = fs_slot;
                        b1_in    = fe_slot;
                        a2_in    = ss_slot;
                        b2_in    = se_slot;
                        state_in = lls_pkg::ST_SW_RD2;
                     end
                  end
                  default: begin
                     if (rc_ff < TAIL_SLOT) begin
                        state_in = lls_pkg::ST_RD_CHK;
                     end
                  end
               endcase
            end
         end

         lls_pkg::ST_APPEND2: begin
            nxt_we   = 1'b1; nxt_wa = a1_ff;     nxt_wd = TAIL_SLOT;
            prv_we   = 1'b1; prv_wa = TAIL_SLOT; prv_wd = a1_ff;
            ap_in    = a1_ff;
            state_in = lls_pkg::ST_IDLE;
         end

         lls_pkg::ST_SW_RD2: begin
            prv_ra     = a2_ff;
            nxt_ra     = b2_ff;
            before1_in = prv_q;
            after1_in  = nxt_q;
            state_in   = lls_pkg::ST_SW_CAP;
         end

         lls_pkg::ST_SW_CAP: begin
            before2_in = prv_q;
            after2_in  = nxt_q;
            if (after1_ff == a2_ff) begin
               mode_in = lls_pkg::MODE_FIRST_BEFORE;
            end else if (nxt_q == a1_ff) begin
               mode_in = lls_pkg::MODE_SECOND_BEFORE;
            end else begin
               mode_in = lls_pkg::MODE_APART;
            end
            step_in  = '0;
            state_in = lls_pkg::ST_SW_JOIN;
         end

         lls_pkg::ST_SW_JOIN: begin
            nxt_we  = 1'b1;
            prv_we  = 1'b1;
            step_in = step_ff + 1'b1;
            if (join_last) begin
               state_in = lls_pkg::ST_TAIL_RD;
            end
         end

         lls_pkg::ST_TAIL_RD: begin
            // new append point is whatever now precedes the tail
            prv_ra   = TAIL_SLOT;
            state_in = lls_pkg::ST_TAIL_CAP;
         end

         lls_pkg::ST_TAIL_CAP: begin
            ap_in    = prv_q;
            state_in = lls_pkg::ST_IDLE;
         end

         lls_pkg::ST_RD_CHK: begin
            if (nxt_q >= TAIL_SLOT) begin
               state_in = lls_pkg::ST_IDLE;
            end else begin
               cur_in   = nxt_q;
               nxt_ra   = nxt_q;
               state_in = lls_pkg::ST_RD_OUT;
            end
         end

         lls_pkg::ST_RD_OUT: begin
            rsp_valid_in   = 1'b1;
            rsp_element_in = cur_wide[lls_pkg::ELEM_W-1:0];
            rsp_is_last_in = (nxt_q == TAIL_SLOT);
            rc_in          = cur_ff;
            state_in       = lls_pkg::ST_IDLE;
         end

         default: begin
            state_in = lls_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lls_pkg::ST_IDLE;
         ap_ff        <= HEAD_SLOT;
         rc_ff        <= HEAD_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ap_ff        <= ap_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a1_ff          <= a1_in;
      b1_ff          <= b1_in;
      a2_ff          <= a2_in;
      b2_ff          <= b2_in;
      before1_ff     <= before1_in;
      after1_ff      <= after1_in;
      before2_ff     <= before2_in;
      after2_ff      <= after2_in;
      mode_ff        <= mode_in;
      step_ff        <= step_in;
      cur_ff         <= cur_in;
      rsp_element_ff <= rsp_element_in;
      rsp_is_last_ff <= rsp_is_last_in;
   end

   assign busy        = (state_ff != lls_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_is_last = rsp_is_last_ff;

endmodule

`default_nettype wire

// File: design/lls_link_ram.sv
// ----------------------------------------------------------------------------
// lls_link_ram : one link table
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_link_ram #(
   parameter int DEPTH = 1026,
   parameter int WIDTH = 11
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: design/lls_checker.sv
// ----------------------------------------------------------------------------
// lls_checker : port level checks for the linked list segment swap core
// Watches the request and response ports only; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic [lls_pkg::KIND_W-1:0] req_kind,
   input wire logic [lls_pkg::ELEM_W-1:0] req_item_value,
   input wire logic                       rsp_valid
);

   logic append_ok;
   assign append_ok = (req_item_value != '0) && (32'(req_item_value) <= 32'(MAX_ELEMENTS));

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

   // clear completes in the accepting cycle
   a_clear_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == lls_pkg::KIND_CLEAR) |=> !busy)
      else $error("clear request left block busy");

   // a valid append passes through ST_APPEND2 and then returns to idle
   a_append_len: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == lls_pkg::KIND_APPEND && append_ok)
      |=> busy ##1 !busy)
      else $error("append request length wrong");

   // results come only right after a busy phase, never two in a row
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a preceding read");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

bind linked_list_segment_swap_core lls_checker #(
   .MAX_ELEMENTS (MAX_ELEMENTS)
) u_lls_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .req_item_value (req_item_value),
   .rsp_valid      (rsp_valid)
);

`default_nettype wire

// File: dv/lls_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_list_checker : read-result checker for the segment swap core
// Mirrors the next/prev link tables from every accepted request and checks
// each returned element and last flag against the predicted list order.
// ----------------------------------------------------------------------------

module lls_list_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [lls_pkg::KIND_W-1:0] req_kind,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_item_value,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_first_start,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_first_end,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_second_start,
   input  wire logic [lls_pkg::ELEM_W-1:0] req_second_end,
   input  wire logic                       rsp_valid,
   input  wire logic [lls_pkg::ELEM_W-1:0] rsp_element,
   input  wire logic                       rsp_is_last,
   output int                              fail_count,
   output int                              pending_reads,
   output int                              compared_reads
);

   localparam int ELEM_W = lls_pkg::ELEM_W;

   localparam logic [ELEM_W-1:0] HEAD_SLOT = '0;
   localparam logic [ELEM_W-1:0] TAIL_SLOT = ELEM_W'(MAX_ELEMENTS + 1);

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic              is_last;
   } read_result_type;

   read_result_type   expected_reads[$];
   logic [ELEM_W-1:0] next_tab [MAX_ELEMENTS+2];
   logic [ELEM_W-1:0] prev_tab [MAX_ELEMENTS+2];
   logic [ELEM_W-1:0] append_at;
   logic [ELEM_W-1:0] cursor;

   function automatic bit in_range(input logic [ELEM_W-1:0] v);
      return (v >= 1) && (v <= MAX_ELEMENTS);
   endfunction

   task automatic link_slots(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
      next_tab[a] = b;
      prev_tab[b] = a;
   endtask

   task automatic swap_segments(input logic [ELEM_W-1:0] a1, input logic [ELEM_W-1:0] b1,
                                input logic [ELEM_W-1:0] a2, input logic [ELEM_W-1:0] b2);
      logic [ELEM_W-1:0] before1, after1, before2, after2;
      lls_pkg::mode_type mode;
      before1 = prev_tab[a1];
      after1  = next_tab[b1];
      before2 = prev_tab[a2];
      after2  = next_tab[b2];
      if (after1 == a2) mode = lls_pkg::MODE_FIRST_BEFORE;
      else if (after2 == a1) mode = lls_pkg::MODE_SECOND_BEFORE;
      else mode = lls_pkg::MODE_APART;
      unique case (mode)
         lls_pkg::MODE_FIRST_BEFORE: begin
            link_slots(before1, a2);
            link_slots(b2, a1);
            link_slots(b1, after2);
         end
         lls_pkg::MODE_SECOND_BEFORE: begin
            link_slots(before2, a1);
            link_slots(b1, a2);
            link_slots(b2, after1);
         end
         default: begin
            link_slots(before1, a2);
            link_slots(b2, after1);
            link_slots(before2, a1);
            link_slots(b1, after2);
         end
      endcase
      append_at = prev_tab[TAIL_SLOT];
   endtask

   task automatic predict_request(input lls_pkg::kind_type k,
                                  input logic [ELEM_W-1:0] v,
                                  input logic [ELEM_W-1:0] fs, input logic [ELEM_W-1:0] fe,
                                  input logic [ELEM_W-1:0] ss, input logic [ELEM_W-1:0] se);
      logic [ELEM_W-1:0] nxt;
      read_result_type   r;
      unique case (k)
         lls_pkg::KIND_CLEAR: begin
            link_slots(HEAD_SLOT, TAIL_SLOT);
            append_at = HEAD_SLOT;
            cursor    = HEAD_SLOT;
         end
         lls_pkg::KIND_APPEND: begin
            if (in_range(v)) begin
               link_slots(append_at, v);
               link_slots(v, TAIL_SLOT);
               append_at = v;
            end
         end
         lls_pkg::KIND_SWAP: begin
            if (in_range(fs) && in_range(fe) && in_range(ss) && in_range(se))
               swap_segments(fs, fe, ss, se);
         end
         default: begin
            // read stops at the tail without moving the cursor
            if (cursor < TAIL_SLOT) begin
               nxt = next_tab[cursor];
               if (nxt < TAIL_SLOT) begin
                  r.element = nxt;
                  r.is_last = (next_tab[nxt] == TAIL_SLOT);
                  expected_reads.push_back(r);
                  cursor = nxt;
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      read_result_type oldest;
      if (reset) begin
         expected_reads.delete();
         for (int i = 0; i < MAX_ELEMENTS + 2; i++) begin
            next_tab[i] = HEAD_SLOT;
            prev_tab[i] = HEAD_SLOT;
         end
         append_at      = HEAD_SLOT;
         cursor         = HEAD_SLOT;
         fail_count     = 0;
         compared_reads = 0;
      end else begin
         // results first: a new request may be taken on the same edge
         if (rsp_valid) begin
            if (expected_reads.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual element %0d is_last %0b",
                        $time, rsp_element, rsp_is_last);
            end else begin
               oldest = expected_reads.pop_front();
               compared_reads++;
               if (rsp_element !== oldest.element) begin
                  fail_count++;
                  $display("%0t: element mismatch, expected %0d, actual %0d",
                           $time, oldest.element, rsp_element);
               end
               if (rsp_is_last !== oldest.is_last) begin
                  fail_count++;
                  $display("%0t: is_last mismatch, expected %0b, actual %0b",
                           $time, oldest.is_last, rsp_is_last);
               end
            end
         end
         if (start && !busy)
            predict_request(lls_pkg::kind_type'(req_kind), req_item_value, req_first_start,
                            req_first_end, req_second_start, req_second_end);
      end
      pending_reads = expected_reads.size();
   end

endmodule

// File: dv/tb_linked_list_segment_swap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_list_segment_swap_core : regression for the segment swap core
// Directed list operations, then random episodes of well-formed lists with
// valid segment swaps mixed with noise; a side checker predicts every read.
// ----------------------------------------------------------------------------

module tb_linked_list_segment_swap_core;

   localparam int KIND_W       = lls_pkg::KIND_W;
   localparam int ELEM_W       = lls_pkg::ELEM_W;
   localparam int MAX_ELEMENTS = 1024;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   // longest request (apart swap) plus the result, with margin
   localparam int DRAIN_CYCLES = 24;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic [KIND_W-1:0] req_kind         = '0;
   logic [ELEM_W-1:0] req_item_value   = '0;
   logic [ELEM_W-1:0] req_first_start  = '0;
   logic [ELEM_W-1:0] req_first_end    = '0;
   logic [ELEM_W-1:0] req_second_start = '0;
   logic [ELEM_W-1:0] req_second_end   = '0;
   logic              busy;
   logic              rsp_valid;
   logic [ELEM_W-1:0] rsp_element;
   logic              rsp_is_last;

   int fail_count;
   int pending_reads;
   int compared_reads;
   int cycle_count = 0;
   int idle_pct    = 0;
   int sent_count  = 0;
   int noise_items = 0;
   int kind_count [4];
   int swaps_adjacent = 0;
   int swaps_apart    = 0;

   // shadow of the list order, only valid inside a well-formed episode
   int order_q[$];
   // values appended at least once since reset: their link entries are written,
   // so only these may be handed to a swap that the block will carry out
   bit linked_ever [MAX_ELEMENTS+1];
   int linked_pool[$];

   always #2 clock = ~clock;

   linked_list_segment_swap_core #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_item_value  (req_item_value),
      .req_first_start (req_first_start),
      .req_first_end   (req_first_end),
      .req_second_start(req_second_start),
      .req_second_end  (req_second_end),
      .rsp_valid       (rsp_valid),
      .rsp_element     (rsp_element),
      .rsp_is_last     (rsp_is_last)
   );

   lls_list_checker #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_item_value  (req_item_value),
      .req_first_start (req_first_start),
      .req_first_end   (req_first_end),
      .req_second_start(req_second_start),
      .req_second_end  (req_second_end),
      .rsp_valid       (rsp_valid),
      .rsp_element     (rsp_element),
      .rsp_is_last     (rsp_is_last),
      .fail_count      (fail_count),
      .pending_reads   (pending_reads),
      .compared_reads  (compared_reads)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("linked_list_segment_swap_core regression: fail");
         $finish;
      end
   end

   // don't-care content for fields a request kind ignores
   function automatic int junk();
      return $urandom_range(0, 2047);
   endfunction

   // mostly a value whose links are known written, sometimes out of range
   function automatic int pool_or_wild();
      if ($urandom_range(7) == 0)
         return $urandom_range(1) ? 0 : $urandom_range(MAX_ELEMENTS + 1, 2047);
      return linked_pool[$urandom_range(linked_pool.size() - 1)];
   endfunction

   // Called at a falling edge. Optional idle cycles first, then hold start
   // until busy is low at a falling edge; the next rising edge takes the
   // request. Returns at the falling edge after acceptance.
   task automatic send_request(input lls_pkg::kind_type k, input int v,
                               input int fs, input int fe, input int ss, input int se);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_kind         <= k;
      req_item_value   <= ELEM_W'(v);
      req_first_start  <= ELEM_W'(fs);
      req_first_end    <= ELEM_W'(fe);
      req_second_start <= ELEM_W'(ss);
      req_second_end   <= ELEM_W'(se);
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      sent_count++;
      kind_count[int'(k)]++;
      if (k == lls_pkg::KIND_APPEND && v >= 1 && v <= MAX_ELEMENTS && !linked_ever[v]) begin
         linked_ever[v] = 1'b1;
         linked_pool.push_back(v);
      end
   endtask

   // hold off until every predicted read has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_reads != 0);
   endtask

   // Clear, build a list of distinct values, then mix valid swaps, reads and
   // further appends while tracking the order, and finish with a read-through
   // that usually runs off the end.
   task automatic run_ordered_episode();
      bit                taken [MAX_ELEMENTS+1];
      int                fill, steps, value, len, p1, q1, p2, q2, r;
      int                rebuilt[$];
      lls_pkg::kind_type op;
      fill  = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      steps = fill + $urandom_range(1, 8);
      send_request(lls_pkg::KIND_CLEAR, junk(), junk(), junk(), junk(), junk());
      order_q.delete();
      for (int i = 0; i < steps; i++) begin
         len = order_q.size();
         if (i < fill) begin
            op = lls_pkg::KIND_APPEND;
         end else begin
            r  = $urandom_range(9);
            op = (r < 5) ? lls_pkg::KIND_SWAP :
                 (r < 8) ? lls_pkg::KIND_READ : lls_pkg::KIND_APPEND;
         end
         if (op == lls_pkg::KIND_SWAP && len < 2) op = lls_pkg::KIND_READ;
         case (op)
            lls_pkg::KIND_APPEND: begin
               do value = $urandom_range(1, MAX_ELEMENTS); while (taken[value]);
               taken[value] = 1'b1;
               send_request(lls_pkg::KIND_APPEND, value, junk(), junk(), junk(), junk());
               order_q.push_back(value);
               // reads interleaved with the build move the cursor part way
               if (i < fill && $urandom_range(5) == 0)
                  send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
            end
            lls_pkg::KIND_SWAP: begin
               // earlier segment [p1..q1], later one [p2..q2]; adjacency biased up
               p1 = $urandom_range(0, len - 2);
               q1 = $urandom_range(p1, len - 2);
               p2 = ($urandom_range(2) == 0) ? q1 + 1 : $urandom_range(q1 + 1, len - 1);
               q2 = $urandom_range(p2, len - 1);
               if (p2 == q1 + 1) swaps_adjacent++;
               else swaps_apart++;
               // either segment may be named first
               if ($urandom_range(1))
                  send_request(lls_pkg::KIND_SWAP, junk(), order_q[p1], order_q[q1],
                               order_q[p2], order_q[q2]);
               else
                  send_request(lls_pkg::KIND_SWAP, junk(), order_q[p2], order_q[q2],
                               order_q[p1], order_q[q1]);
               rebuilt.delete();
               for (int j = 0; j < p1; j++) rebuilt.push_back(order_q[j]);
               for (int j = p2; j <= q2; j++) rebuilt.push_back(order_q[j]);
               for (int j = q1 + 1; j < p2; j++) rebuilt.push_back(order_q[j]);
               for (int j = p1; j <= q1; j++) rebuilt.push_back(order_q[j]);
               for (int j = q2 + 1; j < len; j++) rebuilt.push_back(order_q[j]);
               order_q = rebuilt;
            end
            default:
               send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
         endcase
      end
      repeat ($urandom_range(1, order_q.size() + 2))
         send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
   endtask

   // Noise: duplicate and out-of-range appends, swaps on arbitrary linked
   // values (possibly overlapping, possibly rejected), stray reads and clears.
   task automatic run_noise_episode();
      lls_pkg::kind_type op;
      repeat ($urandom_range(4, 16)) begin
         op = lls_pkg::kind_type'($urandom_range(3));
         case (op)
            lls_pkg::KIND_APPEND:
               send_request(lls_pkg::KIND_APPEND, $urandom_range(1) ? pool_or_wild() : junk(),
                            junk(), junk(), junk(), junk());
            lls_pkg::KIND_SWAP:
               send_request(lls_pkg::KIND_SWAP, junk(), pool_or_wild(), pool_or_wild(),
                            pool_or_wild(), pool_or_wild());
            default: send_request(op, junk(), junk(), junk(), junk(), junk());
         endcase
         noise_items++;
      end
      order_q.delete();
   endtask

   initial begin : stimulus
      int base, progress, phase, last_phase;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_pct = 31;

      // --- directed ---
      // link tables are undefined after reset, so a clear comes first;
      // the read right after it hits an empty list
      send_request(lls_pkg::KIND_CLEAR, junk(), junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 1, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, MAX_ELEMENTS, junk(), junk(), junk(), junk());
      // out of range values are dropped
      send_request(lls_pkg::KIND_APPEND, 0, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 2047, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 5, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 7, junk(), junk(), junk(), junk());
      // 1 1024 5 7: first segment directly before second, starting at head
      send_request(lls_pkg::KIND_SWAP, junk(), 1, 1, MAX_ELEMENTS, MAX_ELEMENTS);
      // 1024 1 5 7: second segment [1..5] directly before first [7]
      send_request(lls_pkg::KIND_SWAP, junk(), 7, 7, 1, 5);
      // 1024 7 1 5: segments apart, touching head and tail
      send_request(lls_pkg::KIND_SWAP, junk(), MAX_ELEMENTS, MAX_ELEMENTS, 5, 5);
      // rejected swap, one end out of range
      send_request(lls_pkg::KIND_SWAP, junk(), 0, 7, 5, 5);
      // 5 7 1 1024: append goes after the new last element
      send_request(lls_pkg::KIND_APPEND, 9, junk(), junk(), junk(), junk());
      // read all five, then twice more at the end
      repeat (7) send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
      // duplicate append rewrites the links unchecked
      send_request(lls_pkg::KIND_CLEAR, junk(), junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 2, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_APPEND, 2, junk(), junk(), junk(), junk());
      send_request(lls_pkg::KIND_READ, junk(), junk(), junk(), junk(), junk());
      wait_drained();

      // --- random episodes in three idle phases: 31%, 64%, none ---
      base       = sent_count;
      last_phase = 0;
      progress   = 0;
      while (progress < RANDOM_ITEMS) begin
         phase    = (progress < RANDOM_ITEMS / 3) ? 0 : (progress < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
         idle_pct = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
         // full drain at each phase change and now and then between episodes
         if (phase != last_phase || $urandom_range(7) == 0) wait_drained();
         last_phase = phase;
         if ($urandom_range(4) == 0) run_noise_episode();
         else run_ordered_episode();
         progress = sent_count - noise_items - base;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d clear, %0d append, %0d swap, %0d read",
               sent_count,
               kind_count[int'(lls_pkg::KIND_CLEAR)],
               kind_count[int'(lls_pkg::KIND_APPEND)],
               kind_count[int'(lls_pkg::KIND_SWAP)],
               kind_count[int'(lls_pkg::KIND_READ)]);
      $display("tracked swaps: %0d adjacent, %0d apart; %0d read results compared",
               swaps_adjacent, swaps_apart, compared_reads);
      if (fail_count == 0)
         $display("linked_list_segment_swap_core regression: pass");
      else
         $display("linked_list_segment_swap_core regression: fail");
      $finish;
   end

endmodule
